/* design/gpio_port_with_pwm_channel_assert.svh */
// Assertion macros for the GPIO port with PWM channel.
// Used by the checker module; depends on a clock clk_i and reset rst_ni in scope.
`ifndef GPIO_PORT_WITH_PWM_CHANNEL_ASSERT_SVH
`define GPIO_PORT_WITH_PWM_CHANNEL_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GPWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpwm assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpwm assertion failed");

`endif

/* design/gpwm_pkg.sv */
// Shared types, register map codes and helper functions for the GPIO port
// with PWM channel. No dependencies.
package gpwm_pkg;

  localparam int unsigned NumPins    = 32;
  localparam int unsigned DivBits    = 12;
  localparam int unsigned DataW      = 32;
  localparam int unsigned FselRows   = 4;
  localparam int unsigned FselPerRow = 10;
  localparam int unsigned FselW      = 3;
  localparam int unsigned FselRowW   = FselPerRow * FselW;
  localparam int unsigned DivLsb     = 12;
  localparam int unsigned PwmCtrlW   = 16;
  localparam int unsigned ClkCtrlW   = 7;

  localparam logic [DataW-1:0] PinMask = DataW'((64'd1 << NumPins) - 64'd1);

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindRead  = 2'd1,
    KindTick  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RegionGpio  = 2'd0,
    RegionPwm   = 2'd1,
    RegionClock = 2'd2
  } region_e;

  localparam logic [5:0] WordFselLast = 6'd3;
  localparam logic [5:0] WordSet      = 6'd7;
  localparam logic [5:0] WordClr      = 6'd10;
  localparam logic [5:0] WordLevel    = 6'd13;
  localparam logic [5:0] WordPwmCtrl  = 6'd0;
  localparam logic [5:0] WordPwmRange = 6'd4;
  localparam logic [5:0] WordPwmData  = 6'd5;
  localparam logic [5:0] WordClkCtrl  = 6'd40;
  localparam logic [5:0] WordClkDiv   = 6'd41;

  localparam logic [7:0] Password = 8'h5A;

  localparam int unsigned PwmEnBit  = 0;
  localparam int unsigned PwmOffBit = 3;
  localparam int unsigned PwmInvBit = 4;
  localparam int unsigned PwmMsBit  = 7;
  localparam int unsigned ClkEnBit  = 4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       region;
    logic [5:0]       word;
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [PwmCtrlW-1:0] pwm_cr;
    logic [DataW-1:0]    pwm_range;
    logic [DataW-1:0]    pwm_data;
    logic                clk_en;
    logic [DivBits-1:0]  divisor;
  } timer_cfg_t;

  // Bits of a function select word that belong to pins which exist.
  function automatic logic [FselRowW-1:0] fsel_row_mask(input int unsigned row);
    logic [FselRowW-1:0] mask;
    mask = '0;
    for (int unsigned i = 0; i < FselPerRow; i++) begin
      if (row * FselPerRow + i < NumPins) begin
        mask[i*FselW +: FselW] = '1;
      end
    end
    return mask;
  endfunction

endpackage

/* design/gpwm_regs.sv */
// Bus register file: function selects, output latch, PWM and clock manager
// registers, with write decode and read mux. Depends on gpwm_pkg.
module gpwm_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  gpwm_pkg::item_t                item_i,
  output logic [gpwm_pkg::DataW-1:0]     rdata_o,
  output logic [gpwm_pkg::DataW-1:0]     latch_o,
  output gpwm_pkg::timer_cfg_t           cfg_o
);
  import gpwm_pkg::*;

  logic [FselRowW-1:0] fsel_q [FselRows];
  logic [FselRowW-1:0] fsel_d [FselRows];
  logic [DataW-1:0]    latch_q, latch_d;
  logic [PwmCtrlW-1:0] pwm_cr_q, pwm_cr_d;
  logic [DataW-1:0]    range_q, range_d;
  logic [DataW-1:0]    data_q, data_d;
  logic [ClkCtrlW-1:0] clk_ctrl_q, clk_ctrl_d;
  logic [DivBits-1:0]  div_q, div_d;
  logic                is_write, is_read, is_fsel, pw_ok;

  assign is_write = (kind_e'(item_i.kind) == KindWrite);
  assign is_read  = (kind_e'(item_i.kind) == KindRead);
  assign is_fsel  = (item_i.word <= WordFselLast);
  assign pw_ok    = (item_i.wdata[DataW-1 -: 8] == Password);

  always_comb begin
    fsel_d     = fsel_q;
    latch_d    = latch_q;
    pwm_cr_d   = pwm_cr_q;
    range_d    = range_q;
    data_d     = data_q;
    clk_ctrl_d = clk_ctrl_q;
    div_d      = div_q;
    if (is_write) begin
      case (region_e'(item_i.region))
        RegionGpio: begin
          if (is_fsel) begin
            for (int unsigned r = 0; r < FselRows; r++) begin
              if (item_i.word[1:0] == 2'(r)) begin
                fsel_d[r] = item_i.wdata[FselRowW-1:0] & fsel_row_mask(r);
              end
            end
          end else if (item_i.word == WordSet) begin
            latch_d = (latch_q | item_i.wdata) & PinMask;
          end else if (item_i.word == WordClr) begin
            latch_d = latch_q & ~item_i.wdata;
          end
        end
        RegionPwm: begin
          if (item_i.word == WordPwmCtrl) begin
            pwm_cr_d = item_i.wdata[PwmCtrlW-1:0];
          end else if (item_i.word == WordPwmRange) begin
            range_d = item_i.wdata;
          end else if (item_i.word == WordPwmData) begin
            data_d = item_i.wdata;
          end
        end
        RegionClock: begin
          // Clock manager writes without the password are dropped.
          if (pw_ok && item_i.word == WordClkCtrl) begin
            clk_ctrl_d = item_i.wdata[ClkCtrlW-1:0];
          end else if (pw_ok && item_i.word == WordClkDiv) begin
            div_d = item_i.wdata[DivLsb +: DivBits];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rdata_o = '0;
    if (is_read) begin
      case (region_e'(item_i.region))
        RegionGpio: begin
          if (is_fsel) begin
            rdata_o = DataW'(fsel_q[item_i.word[1:0]]);
          end else if (item_i.word == WordLevel) begin
            rdata_o = item_i.pin_levels & PinMask;
          end
        end
        RegionPwm: begin
          if (item_i.word == WordPwmCtrl) begin
            rdata_o = DataW'(pwm_cr_q);
          end else if (item_i.word == WordPwmRange) begin
            rdata_o = range_q;
          end else if (item_i.word == WordPwmData) begin
            rdata_o = data_q;
          end
        end
        RegionClock: begin
          // Bit 7 reads as busy, which follows the enable bit.
          if (item_i.word == WordClkCtrl) begin
            rdata_o = DataW'({clk_ctrl_q[ClkEnBit], clk_ctrl_q});
          end else if (item_i.word == WordClkDiv) begin
            rdata_o = DataW'({div_q, {DivLsb{1'b0}}});
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < FselRows; r++) begin
        fsel_q[r] <= '0;
      end
      latch_q    <= '0;
      pwm_cr_q   <= '0;
      range_q    <= '0;
      data_q     <= '0;
      clk_ctrl_q <= '0;
      div_q      <= '0;
    end else if (step_i) begin
      fsel_q     <= fsel_d;
      latch_q    <= latch_d;
      pwm_cr_q   <= pwm_cr_d;
      range_q    <= range_d;
      data_q     <= data_d;
      clk_ctrl_q <= clk_ctrl_d;
      div_q      <= div_d;
    end
  end

  assign latch_o         = latch_d;
  assign cfg_o.pwm_cr    = pwm_cr_d;
  assign cfg_o.pwm_range = range_d;
  assign cfg_o.pwm_data  = data_d;
  assign cfg_o.clk_en    = clk_ctrl_d[ClkEnBit];
  assign cfg_o.divisor   = div_d;

endmodule

/* design/gpwm_timer.sv */
// Clock divider, PWM period counter and output level logic.
// Depends on gpwm_pkg for the configuration struct and bit positions.
module gpwm_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  gpwm_pkg::timer_cfg_t cfg_i,
  output logic                 pwm_o
);
  import gpwm_pkg::*;

  logic [DivBits-1:0] div_cnt_q, div_cnt_d, div_next;
  logic [DataW-1:0]   period_q, period_d;
  logic [DataW:0]     period_inc;
  logic               divided, pwm_en, raw;

  assign pwm_en     = cfg_i.pwm_cr[PwmEnBit];
  assign div_next   = div_cnt_q + 1'b1;
  assign period_inc = {1'b0, period_q} + 1'b1;

  always_comb begin
    div_cnt_d = div_cnt_q;
    period_d  = period_q;
    divided   = 1'b0;
    if (tick_i) begin
      // A divisor of zero is reached only when the count wraps.
      if (cfg_i.clk_en) begin
        if (div_next == cfg_i.divisor) begin
          divided   = 1'b1;
          div_cnt_d = '0;
        end else begin
          div_cnt_d = div_next;
        end
      end
      if (!pwm_en) begin
        period_d = '0;
      end else if (divided) begin
        period_d = (period_inc >= {1'b0, cfg_i.pwm_range}) ? '0 : period_inc[DataW-1:0];
      end
    end
  end

  assign raw   = cfg_i.pwm_cr[PwmMsBit] & (period_d < cfg_i.pwm_data);
  assign pwm_o = pwm_en ? (raw ^ cfg_i.pwm_cr[PwmInvBit]) : cfg_i.pwm_cr[PwmOffBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      period_q  <= '0;
    end else begin
      div_cnt_q <= div_cnt_d;
      period_q  <= period_d;
    end
  end

endmodule

/* design/gpio_port_with_pwm_channel.sv */
// GPIO port with one mark-space PWM channel: top level.
// An accepted input beat passes through the input register, then the result register;
// throughput one beat per cycle while the sink takes results, set by the single pass of the
// register update and counter logic. Reset clears both pipeline valid flags, the output
// latch, the PWM and clock registers and the counters; all function selects read as inputs.
module gpio_port_with_pwm_channel (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [1:0]                 region_i,
  input  logic [5:0]                 word_i,
  input  logic [gpwm_pkg::DataW-1:0] wdata_i,
  input  logic [gpwm_pkg::DataW-1:0] pin_levels_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gpwm_pkg::DataW-1:0] rdata_o,
  output logic [gpwm_pkg::DataW-1:0] out_levels_o,
  output logic                       pwm_out_o
);
  import gpwm_pkg::*;

  item_t            item_q;
  logic             s1_valid_q, s1_move, tick;
  logic             out_valid_q;
  logic [DataW-1:0] rdata_q, levels_q, rdata, latch_d;
  logic             pwm_q, pwm;
  timer_cfg_t       cfg;

  // The held beat moves on whenever the result register is free or being emptied.
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign tick       = s1_move && (kind_e'(item_q.kind) == KindTick);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{kind: kind_i, region: region_i, word: word_i,
                  wdata: wdata_i, pin_levels: pin_levels_i};
    end
  end

  gpwm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_move),
    .item_i  (item_q),
    .rdata_o (rdata),
    .latch_o (latch_d),
    .cfg_o   (cfg)
  );

  gpwm_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .cfg_i  (cfg),
    .pwm_o  (pwm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      rdata_q  <= rdata;
      levels_q <= latch_d & PinMask;
      pwm_q    <= pwm;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rdata_o      = rdata_q;
  assign out_levels_o = levels_q;
  assign pwm_out_o    = pwm_q;

endmodule

/* design/gpwm_checker.sv */
// Port-level checker for the GPIO port with PWM channel, bound to the top level.
// Depends on gpwm_pkg for widths and on the assertion macro header.
`include "gpio_port_with_pwm_channel_assert.svh"

module gpwm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [gpwm_pkg::DataW-1:0] rdata_o,
  input logic [gpwm_pkg::DataW-1:0] out_levels_o,
  input logic                       pwm_out_o
);

  // A result beat that is not taken stays offered.
  `GPWM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // The payload of a waiting result beat does not move.
  `GPWM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(rdata_o) && $stable(out_levels_o) && $stable(pwm_out_o))

  // Input is only held off while a result is waiting.
  `GPWM_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o)

  // A result appearing from an empty output comes from a beat accepted through the input register.
  `GPWM_ASSERT_NOW(a_no_invent, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))

  // With the sink ready after acceptance, an accepted beat passes through the input register and shows up.
  `GPWM_ASSERT_NEXT(a_latency, (in_valid_i && in_ready_o) ##1 out_ready_i, out_valid_o)

endmodule

bind gpio_port_with_pwm_channel gpwm_checker u_gpwm_checker (.*);

/* test/gpio_port_with_pwm_channel_test.sv */
`timescale 1ns / 100ps
// Testbench for gpio_port_with_pwm_channel: directed and random bus writes, reads and ticks,
// each result beat checked against a behavioural model of the port, PWM and clock divider.
// Depends on gpwm_pkg and the RTL top level only.
module gpio_port_with_pwm_channel_test;
  import gpwm_pkg::*;

  // Codes the package leaves unnamed; the block must treat them as no-ops.
  localparam logic [1:0] KindNone   = 2'd3;
  localparam logic [1:0] RegionNone = 2'd3;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 300;

  typedef struct packed {
    logic [DataW-1:0] rdata;
    logic [DataW-1:0] levels;
    logic             pwm;
  } port_result_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [1:0]       kind_i       = '0;
  logic [1:0]       region_i     = '0;
  logic [5:0]       word_i       = '0;
  logic [DataW-1:0] wdata_i      = '0;
  logic [DataW-1:0] pin_levels_i = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [DataW-1:0] rdata_o;
  logic [DataW-1:0] out_levels_o;
  logic             pwm_out_o;

  int unsigned send_idle_pct  = 11;
  int unsigned recv_idle_pct  = 82;
  int unsigned rx_hold_cycles = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;

  port_result_t expected_results[$];

  // Model of the block's state.
  logic [FselW-1:0]    fsel_model [NumPins] = '{default: '0};
  logic [DataW-1:0]    latch_model     = '0;
  logic [PwmCtrlW-1:0] pwm_cr_model    = '0;
  logic [DataW-1:0]    pwm_range_model = '0;
  logic [DataW-1:0]    pwm_data_model  = '0;
  logic [DataW-1:0]    period_model    = '0;
  logic [ClkCtrlW-1:0] clk_ctrl_model  = '0;
  logic [DivBits-1:0]  divisor_model   = '0;
  logic [DivBits-1:0]  div_count_model = '0;

  gpio_port_with_pwm_channel DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .region_i    (region_i),
    .word_i      (word_i),
    .wdata_i     (wdata_i),
    .pin_levels_i(pin_levels_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rdata_o     (rdata_o),
    .out_levels_o(out_levels_o),
    .pwm_out_o   (pwm_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Applies one accepted beat to the model and works out the result it should give.
  task automatic advance_port_model(input item_t beat, output port_result_t res);
    int unsigned        i;
    int unsigned        pin;
    logic               divided;
    logic [DivBits-1:0] next_div;
    logic [DataW:0]     next_period;
    logic               password_ok;
    res         = '0;
    divided     = 1'b0;
    password_ok = (beat.wdata[DataW-1 -: 8] == Password);
    if (beat.kind == KindWrite) begin
      if (beat.region == RegionGpio) begin
        if (beat.word <= WordFselLast) begin
          for (i = 0; i < FselPerRow; i++) begin
            pin = beat.word * FselPerRow + i;
            if (pin < NumPins) fsel_model[pin] = beat.wdata[i*FselW +: FselW];
          end
        end else if (beat.word == WordSet) begin
          latch_model = (latch_model | beat.wdata) & PinMask;
        end else if (beat.word == WordClr) begin
          latch_model = latch_model & ~beat.wdata;
        end
      end else if (beat.region == RegionPwm) begin
        if (beat.word == WordPwmCtrl) pwm_cr_model = beat.wdata[PwmCtrlW-1:0];
        else if (beat.word == WordPwmRange) pwm_range_model = beat.wdata;
        else if (beat.word == WordPwmData) pwm_data_model = beat.wdata;
      end else if (beat.region == RegionClock && password_ok) begin
        if (beat.word == WordClkCtrl) clk_ctrl_model = beat.wdata[ClkCtrlW-1:0];
        else if (beat.word == WordClkDiv) divisor_model = beat.wdata[DivLsb +: DivBits];
      end
    end else if (beat.kind == KindRead) begin
      if (beat.region == RegionGpio) begin
        if (beat.word <= WordFselLast) begin
          for (i = 0; i < FselPerRow; i++) begin
            pin = beat.word * FselPerRow + i;
            if (pin < NumPins) res.rdata[i*FselW +: FselW] = fsel_model[pin];
          end
        end else if (beat.word == WordLevel) begin
          res.rdata = beat.pin_levels & PinMask;
        end
      end else if (beat.region == RegionPwm) begin
        if (beat.word == WordPwmCtrl) res.rdata = DataW'(pwm_cr_model);
        else if (beat.word == WordPwmRange) res.rdata = pwm_range_model;
        else if (beat.word == WordPwmData) res.rdata = pwm_data_model;
      end else if (beat.region == RegionClock) begin
        // The busy flag sits just above the stored bits and mirrors the enable.
        if (beat.word == WordClkCtrl) begin
          res.rdata = DataW'({clk_ctrl_model[ClkEnBit], clk_ctrl_model});
        end else if (beat.word == WordClkDiv) begin
          res.rdata = DataW'(divisor_model) << DivLsb;
        end
      end
    end else if (beat.kind == KindTick) begin
      if (clk_ctrl_model[ClkEnBit]) begin
        next_div = div_count_model + 1'b1;
        if (next_div == divisor_model) begin
          divided         = 1'b1;
          div_count_model = '0;
        end else begin
          div_count_model = next_div;
        end
      end
      if (!pwm_cr_model[PwmEnBit]) begin
        period_model = '0;
      end else if (divided) begin
        next_period  = {1'b0, period_model} + 1'b1;
        period_model = (next_period >= {1'b0, pwm_range_model}) ? '0 : next_period[DataW-1:0];
      end
    end
    res.levels = latch_model & PinMask;
    if (!pwm_cr_model[PwmEnBit]) begin
      res.pwm = pwm_cr_model[PwmOffBit];
    end else begin
      res.pwm = (pwm_cr_model[PwmMsBit] && (period_model < pwm_data_model))
                ^ pwm_cr_model[PwmInvBit];
    end
  endtask

  // Offers one beat, holds it until accepted, then records what it should produce.
  task automatic send_beat(input logic [1:0] kind, input logic [1:0] region,
                           input logic [5:0] word, input logic [DataW-1:0] wdata);
    item_t        beat;
    port_result_t res;
    beat.kind       = kind;
    beat.region     = region;
    beat.word       = word;
    beat.wdata      = wdata;
    beat.pin_levels = $urandom();
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    kind_i       <= beat.kind;
    region_i     <= beat.region;
    word_i       <= beat.word;
    wdata_i      <= beat.wdata;
    pin_levels_i <= beat.pin_levels;
    do @(posedge clk_i); while (!in_ready_o);
    advance_port_model(beat, res);
    expected_results.push_back(res);
  endtask

  task automatic compare_field(input string name, input logic [DataW-1:0] want,
                               input logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    port_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, rdata %h", $time, rdata_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("rdata", want.rdata, rdata_o);
        compare_field("out_levels", want.levels, out_levels_o);
        compare_field("pwm_out", DataW'(want.pwm), DataW'(pwm_out_o));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while rx_hold_cycles runs down.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_gpio_map();
    send_beat(KindWrite, RegionGpio, 6'd0, 32'h3FFF_FFFF);
    send_beat(KindWrite, RegionGpio, WordFselLast, 32'hFFFF_FFFF);
    send_beat(KindRead, RegionGpio, 6'd0, 32'h0);
    send_beat(KindRead, RegionGpio, WordFselLast, 32'h0);
    send_beat(KindWrite, RegionGpio, WordSet, 32'hFFFF_FFFF);
    send_beat(KindWrite, RegionGpio, WordClr, 32'h0F0F_0F0F);
    send_beat(KindRead, RegionGpio, WordSet, 32'h0);
    send_beat(KindRead, RegionGpio, WordClr, 32'h0);
    send_beat(KindRead, RegionGpio, WordLevel, 32'h0);
  endtask

  task automatic test_clock_manager();
    // A write without the password must leave the clock disabled.
    send_beat(KindWrite, RegionClock, WordClkCtrl, 32'h0000_0010);
    send_beat(KindRead, RegionClock, WordClkCtrl, 32'h0);
    send_beat(KindWrite, RegionClock, WordClkCtrl, {Password, 24'h0000FF});
    send_beat(KindWrite, RegionClock, WordClkDiv, {Password, 24'hFFFFFF});
    send_beat(KindRead, RegionClock, WordClkDiv, 32'h0);
  endtask

  task automatic test_pwm_channel();
    // Divisor one gives a divided clock on every tick.
    send_beat(KindWrite, RegionClock, WordClkDiv, {Password, 24'h001000});
    send_beat(KindWrite, RegionPwm, WordPwmRange, 32'd2);
    send_beat(KindWrite, RegionPwm, WordPwmData, 32'd3);
    send_beat(KindWrite, RegionPwm, WordPwmCtrl, 32'h0000_0091);
    send_beat(KindTick, RegionGpio, 6'd0, 32'h0);
    send_beat(KindWrite, RegionPwm, WordPwmData, 32'd1);
    send_beat(KindTick, RegionGpio, 6'd0, 32'h0);
    send_beat(KindTick, RegionGpio, 6'd0, 32'h0);
    send_beat(KindWrite, RegionPwm, WordPwmCtrl, 32'h0000_0011);
    send_beat(KindWrite, RegionPwm, WordPwmRange, 32'd0);
    send_beat(KindTick, RegionGpio, 6'd0, 32'h0);
    send_beat(KindWrite, RegionPwm, WordPwmCtrl, 32'hFFFF_0008);
    send_beat(KindRead, RegionPwm, WordPwmCtrl, 32'h0);
  endtask

  task automatic test_unmapped_access();
    send_beat(KindWrite, RegionNone, WordSet, 32'hFFFF_FFFF);
    send_beat(KindNone, RegionGpio, WordSet, 32'hFFFF_FFFF);
  endtask

  // Mostly well-formed register traffic and ticks with small divisors and ranges,
  // so that the PWM period runs through many cycles; the rest is noise.
  task automatic random_beat();
    logic [DataW-1:0] d;
    logic [1:0]       region;
    logic [5:0]       word;
    int unsigned      pick;
    d      = $urandom();
    region = 2'($urandom_range(2));
    word   = 6'($urandom());
    pick   = $urandom_range(99);
    if (pick < 45) begin
      send_beat(KindTick, region, word, d);
    end else if (pick < 60) begin
      case ($urandom_range(5))
        0: begin region = RegionGpio; word = 6'($urandom_range(3)); end
        1: begin region = RegionGpio; word = WordLevel; end
        2: begin region = RegionPwm; word = WordPwmCtrl; end
        3: begin
          region = RegionPwm;
          word   = ($urandom_range(1) != 0) ? WordPwmRange : WordPwmData;
        end
        4: begin
          region = RegionClock;
          word   = ($urandom_range(1) != 0) ? WordClkCtrl : WordClkDiv;
        end
        default: ;
      endcase
      send_beat(KindRead, region, word, d);
    end else if (pick < 88) begin
      case ($urandom_range(6))
        0: begin region = RegionGpio; word = 6'($urandom_range(3)); end
        1: begin
          region = RegionGpio;
          word   = ($urandom_range(1) != 0) ? WordSet : WordClr;
        end
        2: begin
          region = RegionPwm;
          word   = WordPwmCtrl;
          if ($urandom_range(3) != 0) d[PwmEnBit] = 1'b1;
          if ($urandom_range(2) != 0) d[PwmMsBit] = 1'b1;
        end
        3: begin
          region = RegionPwm;
          word   = WordPwmRange;
          if ($urandom_range(7) != 0) d = $urandom_range(12);
        end
        4: begin
          region = RegionPwm;
          word   = WordPwmData;
          if ($urandom_range(7) != 0) d = $urandom_range(15);
        end
        5: begin
          region = RegionClock;
          word   = WordClkCtrl;
          if ($urandom_range(3) != 0) d[ClkEnBit] = 1'b1;
        end
        default: begin
          region = RegionClock;
          word   = WordClkDiv;
          if ($urandom_range(7) != 0) d[DivLsb +: DivBits] = DivBits'($urandom_range(6));
        end
      endcase
      // Most clock manager writes carry the password; the rest must be refused.
      if (region == RegionClock && $urandom_range(9) != 0) d[DataW-1 -: 8] = Password;
      send_beat(KindWrite, region, word, d);
    end else begin
      send_beat(2'($urandom()), 2'($urandom()), 6'($urandom()), $urandom());
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) random_beat();
  endtask

  // The receiver stops for a long stretch while beats keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_backpressure();
    rx_hold_cycles = HoldCycles;
    repeat (40) random_beat();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_gpio_map();
    test_clock_manager();
    test_pwm_channel();
    test_unmapped_access();
    test_random_traffic(650);
    send_idle_pct = 82;
    recv_idle_pct = 11;
    test_random_traffic(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(580);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/gpwm_pkg.sv
design/gpwm_regs.sv
design/gpwm_timer.sv
design/gpio_port_with_pwm_channel.sv
design/gpwm_checker.sv
test/gpio_port_with_pwm_channel_test.sv
